>>> design/sps_pkg.sv
// shared types, constants and helpers for the sps dimension parser
package sps_pkg;

    localparam int MaxCodeBitsDefault = 32;
    localparam int QueueDepth = 2;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_TRUNCATED = 2'd1;
    localparam logic [1:0] STATUS_RANGE     = 2'd2;

    localparam logic [5:0] ST_PROFILE    = 6'd0;
    localparam logic [5:0] ST_CONSTR     = 6'd1;
    localparam logic [5:0] ST_LEVEL      = 6'd2;
    localparam logic [5:0] ST_SPS_ID     = 6'd3;
    localparam logic [5:0] ST_CHROMA     = 6'd4;
    localparam logic [5:0] ST_RESID      = 6'd5;
    localparam logic [5:0] ST_DEPTH_L    = 6'd6;
    localparam logic [5:0] ST_DEPTH_C    = 6'd7;
    localparam logic [5:0] ST_BYPASS     = 6'd8;
    localparam logic [5:0] ST_MATRIX     = 6'd9;
    localparam logic [5:0] ST_LIST_FLAG  = 6'd10;
    localparam logic [5:0] ST_DELTA      = 6'd11;
    localparam logic [5:0] ST_FRAME_NUM  = 6'd12;
    localparam logic [5:0] ST_POC_TYPE   = 6'd13;
    localparam logic [5:0] ST_POC_LSB    = 6'd14;
    localparam logic [5:0] ST_POC_ZERO   = 6'd15;
    localparam logic [5:0] ST_OFF_NONREF = 6'd16;
    localparam logic [5:0] ST_OFF_TB     = 6'd17;
    localparam logic [5:0] ST_CYCLE      = 6'd18;
    localparam logic [5:0] ST_OFF_REF    = 6'd19;
    localparam logic [5:0] ST_NUM_REF    = 6'd20;
    localparam logic [5:0] ST_GAPS       = 6'd21;
    localparam logic [5:0] ST_WIDTH      = 6'd22;
    localparam logic [5:0] ST_HEIGHT     = 6'd23;
    localparam logic [5:0] ST_FRAME_ONLY = 6'd24;
    localparam logic [5:0] ST_MBAFF      = 6'd25;
    localparam logic [5:0] ST_DIRECT     = 6'd26;
    localparam logic [5:0] ST_CROP_FLAG  = 6'd27;
    localparam logic [5:0] ST_CROP0      = 6'd28;
    localparam logic [5:0] ST_CROP1      = 6'd29;
    localparam logic [5:0] ST_CROP2      = 6'd30;
    localparam logic [5:0] ST_CROP3      = 6'd31;

    localparam logic [15:0] SAT16 = 16'hFFFF;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       last_byte;
    } byte_req_t;

    typedef struct packed {
        logic [15:0] pic_width;
        logic [15:0] pic_height;
        logic [7:0]  profile;
        logic [7:0]  level;
        logic [1:0]  status;
    } result_t;

    // fixed field width per step, zero for exp-golomb
    function automatic logic [3:0] field_bits(input logic [5:0] step);
        logic [3:0] n;
        begin
            case (step)
                ST_PROFILE, ST_CONSTR, ST_LEVEL: n = 4'd8;
                ST_RESID, ST_BYPASS, ST_MATRIX, ST_LIST_FLAG, ST_POC_ZERO,
                ST_GAPS, ST_FRAME_ONLY, ST_MBAFF, ST_DIRECT, ST_CROP_FLAG: n = 4'd1;
                default: n = 4'd0;
            endcase
            return n;
        end
    endfunction

endpackage

>>> design/sps_front.sv
// front end: byte intake and request queue
module sps_front
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  sps_pkg::byte_req_t    push_req,
    output logic                  req_valid,
    output sps_pkg::byte_req_t    req,
    input  logic                  req_take
);
    import sps_pkg::*;

    byte_req_t  mem_reg [QueueDepth];
    logic [0:0] wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push, do_pop;

    assign full      = (count_reg == 2'(QueueDepth));
    assign req_valid = (count_reg != 2'd0);
    assign req       = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = req_take && req_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + 2'(do_push) - 2'(do_pop);
        end
    end
endmodule

>>> design/sps_back.sv
// back end: bit-serial sps syntax walker
module sps_back
#(
    parameter int MAX_CODE_BITS = sps_pkg::MaxCodeBitsDefault
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  sps_pkg::byte_req_t  req,
    output logic                req_take,
    output logic                res_valid,
    output sps_pkg::result_t    res,
    input  logic                res_take
);
    import sps_pkg::*;

    logic [5:0]  step_reg, step_next;
    logic        phase_reg, phase_next;
    logic [5:0]  zeros_reg, zeros_next;
    logic [5:0]  left_reg, left_next;
    logic [31:0] acc_reg, acc_next;
    logic [7:0]  prof_reg, prof_next, lvl_reg, lvl_next;
    logic [7:0]  loop_reg, loop_next;
    logic [3:0]  list_reg, list_next;
    logic [6:0]  coef_reg, coef_next;
    logic [7:0]  lscale_reg, lscale_next;
    logic [15:0] wmb_reg, wmb_next, hmu_reg, hmu_next;
    logic        fonly_reg, fonly_next;
    logic [15:0] crop_reg [4];
    logic [15:0] crop_next [4];
    logic        done_reg, done_next;
    logic [2:0]  bit_reg, bit_next;
    logic        busy_reg, busy_next;
    logic        fin_reg, fin_next;
    logic        res_valid_reg, res_valid_next;
    result_t     res_reg, res_next;

    // request held while its bits are walked
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;

    // final dimension stage registers
    logic signed [22:0] w_reg, w_next, h_reg, h_next;
    logic               bad_reg, bad_next;

    logic        b;
    logic [3:0]  n;
    logic [31:0] v;
    logic        fd;
    logic        emit_now;
    result_t     emit_val;
    logic [7:0]  delta, nscale;
    logic [32:0] vp1;

    assign req_take  = req_valid && !busy_reg && !fin_reg && !res_valid_reg;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;
    assign b         = in_byte_reg[3'd7 - bit_reg];
    assign n         = field_bits(step_reg);

    function automatic logic [15:0] sat(input logic [32:0] x);
        begin
            return (x > 33'(SAT16)) ? SAT16 : x[15:0];
        end
    endfunction

    always_comb
    begin
        step_next = step_reg; phase_next = phase_reg; zeros_next = zeros_reg;
        left_next = left_reg; acc_next = acc_reg; prof_next = prof_reg;
        lvl_next = lvl_reg; loop_next = loop_reg; list_next = list_reg;
        coef_next = coef_reg; lscale_next = lscale_reg; wmb_next = wmb_reg;
        hmu_next = hmu_reg; fonly_next = fonly_reg; crop_next = crop_reg;
        done_next = done_reg; bit_next = bit_reg; busy_next = busy_reg;
        fin_next = 1'b0; res_valid_next = res_valid_reg; res_next = res_reg;
        w_next = w_reg; h_next = h_reg; bad_next = bad_reg;
        fd = 1'b0; v = '0; emit_now = 1'b0;
        emit_val = '{16'd0, 16'd0, prof_reg, lvl_reg, STATUS_RANGE};
        delta = '0; nscale = '0; vp1 = '0;

        if (res_valid_reg && res_take)
        begin
            res_valid_next = 1'b0;
        end

        if (fin_reg)
        begin
            res_valid_next = 1'b1;
            res_next = '{16'd0, 16'd0, prof_reg, lvl_reg, STATUS_RANGE};
            if (!(bad_reg || w_reg < 0 || h_reg < 0 || w_reg > 23'sd65535
                  || h_reg > 23'sd65535))
            begin
                res_next = '{w_reg[15:0], h_reg[15:0], prof_reg, lvl_reg, STATUS_OK};
            end
            done_next = 1'b1;
            busy_next = 1'b1;
        end
        else if (req_take)
        begin
            busy_next = 1'b1;
            bit_next  = 3'd0;
        end
        else if (busy_reg)
        begin
            if (!done_reg)
            begin
                if (phase_reg == 1'b0)
                begin
                    if (n != 4'd0)
                    begin
                        phase_next = 1'b1;
                        acc_next   = 32'(b);
                        left_next  = 6'(n) - 6'd1;
                        if (n == 4'd1)
                        begin
                            fd = 1'b1;
                            v  = 32'(b);
                            phase_next = 1'b0;
                            acc_next = '0;
                        end
                    end
                    else if (!b)
                    begin
                        zeros_next = zeros_reg + 6'd1;
                        if (32'(zeros_next) >= 32'(MAX_CODE_BITS))
                        begin
                            emit_now = 1'b1;
                        end
                    end
                    else if (zeros_reg == 6'd0)
                    begin
                        fd = 1'b1;
                    end
                    else
                    begin
                        phase_next = 1'b1;
                        left_next  = zeros_reg;
                        acc_next   = '0;
                    end
                end
                else
                begin
                    acc_next  = {acc_reg[30:0], b};
                    left_next = left_reg - 6'd1;
                    if (left_next == 6'd0)
                    begin
                        fd = 1'b1;
                        v  = acc_next;
                        if (n == 4'd0)
                        begin
                            v = ((32'd1 << zeros_reg[4:0]) - 32'd1) + acc_next;
                        end
                        phase_next = 1'b0;
                        zeros_next = '0;
                        acc_next   = '0;
                    end
                end

                if (fd)
                begin
                    vp1 = 33'(v) + 33'd1;
                    case (step_reg)
                        ST_PROFILE: begin prof_next = v[7:0]; step_next = ST_CONSTR; end
                        ST_CONSTR: step_next = ST_LEVEL;
                        ST_LEVEL: begin lvl_next = v[7:0]; step_next = ST_SPS_ID; end
                        ST_SPS_ID:
                            step_next = (prof_reg inside {8'd100, 8'd110, 8'd122, 8'd144})
                                        ? ST_CHROMA : ST_FRAME_NUM;
                        ST_CHROMA:
                        begin
                            loop_next = (v == 32'd3) ? 8'd12 : 8'd8;
                            step_next = (v == 32'd3) ? ST_RESID : ST_DEPTH_L;
                        end
                        ST_RESID: step_next = ST_DEPTH_L;
                        ST_DEPTH_L: step_next = ST_DEPTH_C;
                        ST_DEPTH_C: step_next = ST_BYPASS;
                        ST_BYPASS: step_next = ST_MATRIX;
                        ST_MATRIX:
                        begin
                            list_next = '0;
                            step_next = v[0] ? ST_LIST_FLAG : ST_FRAME_NUM;
                        end
                        ST_LIST_FLAG:
                        begin
                            if (v[0])
                            begin
                                coef_next = '0;
                                lscale_next = 8'd8;
                                step_next = ST_DELTA;
                            end
                            else
                            begin
                                list_next = list_reg + 4'd1;
                                step_next = (8'(list_next) >= loop_reg)
                                            ? ST_FRAME_NUM : ST_LIST_FLAG;
                            end
                        end
                        ST_DELTA:
                        begin
                            delta = v[0] ? (v[8:1] + 8'd1) : (8'd0 - v[8:1]);
                            nscale = lscale_reg + delta;
                            if (nscale != 8'd0)
                            begin
                                lscale_next = nscale;
                            end
                            coef_next = coef_reg + 7'd1;
                            if (nscale == 8'd0
                                || coef_next >= ((list_reg < 4'd6) ? 7'd16 : 7'd64))
                            begin
                                list_next = list_reg + 4'd1;
                                step_next = (8'(list_next) >= loop_reg)
                                            ? ST_FRAME_NUM : ST_LIST_FLAG;
                            end
                        end
                        ST_FRAME_NUM: step_next = ST_POC_TYPE;
                        ST_POC_TYPE:
                            step_next = (v == 32'd0) ? ST_POC_LSB
                                      : (v == 32'd1) ? ST_POC_ZERO : ST_NUM_REF;
                        ST_POC_LSB: step_next = ST_NUM_REF;
                        ST_POC_ZERO: step_next = ST_OFF_NONREF;
                        ST_OFF_NONREF: step_next = ST_OFF_TB;
                        ST_OFF_TB: step_next = ST_CYCLE;
                        ST_CYCLE:
                        begin
                            if (v > 32'd255)
                            begin
                                emit_now = 1'b1;
                            end
                            else
                            begin
                                loop_next = v[7:0];
                                step_next = (v == 32'd0) ? ST_NUM_REF : ST_OFF_REF;
                            end
                        end
                        ST_OFF_REF:
                        begin
                            loop_next = loop_reg - 8'd1;
                            if (loop_next == 8'd0)
                            begin
                                step_next = ST_NUM_REF;
                            end
                        end
                        ST_NUM_REF: step_next = ST_GAPS;
                        ST_GAPS: step_next = ST_WIDTH;
                        ST_WIDTH: begin wmb_next = sat(vp1); step_next = ST_HEIGHT; end
                        ST_HEIGHT: begin hmu_next = sat(vp1); step_next = ST_FRAME_ONLY; end
                        ST_FRAME_ONLY:
                        begin
                            fonly_next = v[0];
                            step_next = v[0] ? ST_DIRECT : ST_MBAFF;
                        end
                        ST_MBAFF: step_next = ST_DIRECT;
                        ST_DIRECT: step_next = ST_CROP_FLAG;
                        ST_CROP_FLAG:
                        begin
                            if (!v[0])
                            begin
                                fin_next = 1'b1;
                            end
                            else
                            begin
                                step_next = ST_CROP0;
                            end
                        end
                        ST_CROP0, ST_CROP1, ST_CROP2, ST_CROP3:
                        begin
                            crop_next[step_reg[1:0]] = sat({1'b0, v});
                            if (step_reg == ST_CROP3)
                            begin
                                fin_next = 1'b1;
                            end
                            else
                            begin
                                step_next = step_reg + 6'd1;
                            end
                        end
                        default: emit_now = 1'b1;
                    endcase
                end

                if (emit_now)
                begin
                    res_valid_next = 1'b1;
                    res_next  = emit_val;
                    done_next = 1'b1;
                    fin_next  = 1'b0;
                end
                if (fin_next)
                begin
                    // pre-compute cropped size, result formed next cycle
                    bad_next = (wmb_next == SAT16) || (hmu_next == SAT16)
                               || (crop_next[0] == SAT16) || (crop_next[1] == SAT16)
                               || (crop_next[2] == SAT16) || (crop_next[3] == SAT16);
                    w_next = $signed({3'd0, wmb_next, 4'd0})
                             - $signed({5'd0, 17'({1'b0, crop_next[0]}
                                                  + {1'b0, crop_next[1]}), 1'b0});
                    h_next = $signed(fonly_next ? {3'd0, hmu_next, 4'd0}
                                                : {2'd0, hmu_next, 5'd0})
                             - $signed({5'd0, 17'({1'b0, crop_next[2]}
                                                  + {1'b0, crop_next[3]}), 1'b0});
                    busy_next = 1'b0;
                end
            end

            if (!fin_next)
            begin
                bit_next = bit_reg + 3'd1;
                if (bit_reg == 3'd7 || done_next)
                begin
                    busy_next = 1'b0;
                    bit_next  = 3'd0;
                end
            end
        end

        // end of set: truncation result and restart
        if (!busy_next && !fin_next && busy_reg && !fin_reg && in_last_reg)
        begin
            if (!done_next && !res_valid_next)
            begin
                res_valid_next = 1'b1;
                res_next = '{16'd0, 16'd0, prof_next, lvl_next, STATUS_TRUNCATED};
            end
            step_next = ST_PROFILE; phase_next = 1'b0; zeros_next = '0;
            left_next = '0; acc_next = '0; prof_next = '0; lvl_next = '0;
            loop_next = '0; list_next = '0; coef_next = '0; lscale_next = 8'd8;
            wmb_next = '0; hmu_next = '0; fonly_next = 1'b1;
            crop_next = '{16'd0, 16'd0, 16'd0, 16'd0}; done_next = 1'b0;
        end
        else if (fin_reg && in_last_reg)
        begin
            step_next = ST_PROFILE; prof_next = '0; lvl_next = '0;
            loop_next = '0; list_next = '0; wmb_next = '0; hmu_next = '0;
            fonly_next = 1'b1; crop_next = '{16'd0, 16'd0, 16'd0, 16'd0};
            done_next = 1'b0; busy_next = 1'b0; phase_next = 1'b0;
            zeros_next = '0; acc_next = '0; left_next = '0; lscale_next = 8'd8;
            coef_next = '0;
        end
        else if (fin_reg)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        w_reg   <= w_next;
        h_reg   <= h_next;
        bad_reg <= bad_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_byte_reg <= '0;
            in_last_reg <= 1'b0;
        end
        else if (req_take)
        begin
            in_byte_reg <= req.byte_value;
            in_last_reg <= req.last_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= ST_PROFILE; phase_reg <= 1'b0; zeros_reg <= '0;
            left_reg <= '0; acc_reg <= '0; prof_reg <= '0; lvl_reg <= '0;
            loop_reg <= '0; list_reg <= '0; coef_reg <= '0; lscale_reg <= 8'd8;
            wmb_reg <= '0; hmu_reg <= '0; fonly_reg <= 1'b1;
            crop_reg <= '{16'd0, 16'd0, 16'd0, 16'd0};
            done_reg <= 1'b0; bit_reg <= '0; busy_reg <= 1'b0; fin_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next; phase_reg <= phase_next; zeros_reg <= zeros_next;
            left_reg <= left_next; acc_reg <= acc_next; prof_reg <= prof_next;
            lvl_reg <= lvl_next; loop_reg <= loop_next; list_reg <= list_next;
            coef_reg <= coef_next; lscale_reg <= lscale_next; wmb_reg <= wmb_next;
            hmu_reg <= hmu_next; fonly_reg <= fonly_next; crop_reg <= crop_next;
            done_reg <= done_next; bit_reg <= bit_next; busy_reg <= busy_next;
            fin_reg <= fin_next; res_valid_reg <= res_valid_next;
        end
    end
endmodule

>>> design/h264_sps_dimension_parser.sv
// top level of the sps dimension parser
//   channel  | handshake    | fields
//   bytes in | push / full  | byte_value, last_byte
//   result   | empty / pop  | pic_width, pic_height, profile, level, status
// each byte is loaded, then its bits are walked in order; at parse end
// the final dimension stage forms the result
// reset clears the queue and restarts the walk at the profile byte
// a waiting result stalls the walker; the two-entry queue absorbs input
module h264_sps_dimension_parser
#(
    parameter int MAX_CODE_BITS = sps_pkg::MaxCodeBitsDefault
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  byte_value,
    input  logic        last_byte,
    output logic        empty,
    input  logic        pop,
    output logic [15:0] pic_width,
    output logic [15:0] pic_height,
    output logic [7:0]  profile,
    output logic [7:0]  level,
    output logic [1:0]  status
);
    import sps_pkg::*;

    byte_req_t push_req, req;
    logic      req_valid, req_take, res_valid;
    result_t   res;

    assign push_req = '{byte_value, last_byte};

    sps_front u_front
    (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .push_req(push_req),
        .req_valid(req_valid), .req(req), .req_take(req_take)
    );

    sps_back #(.MAX_CODE_BITS(MAX_CODE_BITS)) u_back
    (
        .clk(clk), .rst_n(rst_n), .req_valid(req_valid), .req(req),
        .req_take(req_take), .res_valid(res_valid), .res(res), .res_take(pop)
    );

    assign empty      = !res_valid;
    assign pic_width  = res.pic_width;
    assign pic_height = res.pic_height;
    assign profile    = res.profile;
    assign level      = res.level;
    assign status     = res.status;
endmodule

>>> design/sps_checker.sv
// port-level checks for the sps dimension parser
module sps_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        empty,
    input logic        pop,
    input logic [15:0] pic_width,
    input logic [15:0] pic_height,
    input logic [1:0]  status
);
    import sps_pkg::*;

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (status == STATUS_OK || status == STATUS_TRUNCATED
                    || status == STATUS_RANGE))
        else $error("bad status code");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status != STATUS_OK) |-> (pic_width == 16'd0 && pic_height == 16'd0))
        else $error("nonzero size on error");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(status) && $stable(pic_width)))
        else $error("result changed while waiting");

    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> empty)
        else $error("result present after reset");
endmodule

bind h264_sps_dimension_parser sps_checker u_sps_checker
(
    .clk(clk), .rst_n(rst_n), .empty(empty), .pop(pop),
    .pic_width(pic_width), .pic_height(pic_height), .status(status)
);
